### hdl/rac_pkg.sv
// Package for the real-time admission control block: types and constants.
package rac_pkg;
  localparam int SLOTS_DEF = 8;
  localparam int TIME_BITS_DEF = 48;

  localparam logic [1:0] MODE_SUBMIT = 2'd0;
  localparam logic [1:0] MODE_SET = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_DEADLINE = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [9:0] VAL_MAX = 10'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input transaction
    logic prep;      // decode and check the addressed entry
    logic div_start; // start the frame-time divider
    logic scan;      // examine one slot; the addressed slot is skipped
    logic finish;    // compute the result and update state
    logic out_take;  // result consumed
  } rac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic need_div;
    logic div_done;
    logic scan_last;
  } rac_sts_t;
endpackage

### hdl/rac_ctrl.sv
// Controller state machine for the admission control block.
module rac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rac_pkg::rac_sts_t sts,
  output rac_pkg::rac_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else if (sts.need_scan) state_next = S_SCAN;
        else state_next = S_FIN;
      end
      S_DIV: if (sts.div_done) state_next = S_FIN;
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.out_take = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### hdl/rac_dp.sv
// Datapath for the admission control block: slot table, scan and frame divider.
module rac_dp #(
  parameter int SLOTS = rac_pkg::SLOTS_DEF,
  parameter int TIME_BITS = rac_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rac_pkg::rac_cmd_t    cmd,
  output rac_pkg::rac_sts_t    sts,
  input  logic                 realtime_enable,
  input  logic [1:0]           mode,
  input  logic [2:0]           slot,
  input  logic [47:0]          now_us,
  input  logic signed [10:0]   fps_in,
  input  logic signed [10:0]   met_ms_in,
  input  logic signed [10:0]   tolerance_ms_in,
  output logic [1:0]           status,
  output logic                 forwarded,
  output logic [47:0]          booked_time_us,
  output logic [47:0]          last_arrival_us,
  output logic [9:0]           fps_out,
  output logic [9:0]           met_ms_out,
  output logic [9:0]           tolerance_ms_out
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TB = TIME_BITS;
  localparam logic [TB-1:0] TMAX = '1;

  // Slot table.
  logic [SLOTS-1:0] s_valid;
  logic [9:0]       s_fps [SLOTS];
  logic [9:0]       s_met [SLOTS];
  logic [9:0]       s_tol [SLOTS];
  logic [19:0]      s_frame [SLOTS];
  logic [TB-1:0]    s_last [SLOTS];
  logic [TB-1:0]    booked;

  // Captured transaction.
  logic [1:0]         r_mode;
  logic [2:0]         r_slot;
  logic [TB-1:0]      r_now;
  logic signed [10:0] r_f, r_m, r_t;
  logic               r_rt;

  // Prepared values.
  logic          p_inrange;
  logic [IW-1:0] p_idx;
  logic [9:0]    p_f, p_m, p_t;
  logic          p_bad;
  logic          p_was_valid;

  // Scan state.
  logic [CW-1:0] scan_i;
  logic          has_dl;
  logic [TB-1:0] deadline;

  // Divider for 1000000 / fps.
  logic [19:0] dv_q;
  logic [19:0] dv_r;
  logic [4:0]  dv_cnt;
  logic        dv_busy;

  function automatic logic [TB-1:0] tadd(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TB] ? TMAX : s[TB-1:0];
  endfunction

  // Prepare decode (combinational on captured transaction).
  logic          c_inrange;
  logic [IW-1:0] c_idx;
  logic          c_valid;
  logic signed [11:0] c_f, c_m, c_t;
  logic          c_bad;
  always_comb begin
    c_inrange = ({29'd0, r_slot} < SLOTS);
    c_idx = IW'(r_slot);
    c_valid = c_inrange && s_valid[c_idx];
    c_f = {r_f[10], r_f};
    c_m = {r_m[10], r_m};
    c_t = {r_t[10], r_t};
    c_bad = 1'b0;
    if (c_valid) begin
      if (r_f < 0) c_f = {2'b00, s_fps[c_idx]};
      if (r_m < 0) c_m = {2'b00, s_met[c_idx]};
      if (r_t < 0) c_t = {2'b00, s_tol[c_idx]};
    end else if (r_f < 0 || r_m < 0 || r_t < 0) begin
      c_bad = 1'b1;
    end
    if (c_f > 12'sd1000 || c_m > 12'sd1000 || c_t > 12'sd1000) c_bad = 1'b1;
    if (!c_inrange) c_bad = 1'b1;
  end

  // Submit that reaches the scan: met of the entry (zeroed if absent) nonzero.
  logic c_sub_met_nz;
  assign c_sub_met_nz = c_valid && (s_met[c_idx] != 10'd0);

  assign sts.need_div = (r_mode == rac_pkg::MODE_SET) && !c_bad && (c_f != 12'sd0);
  assign sts.need_scan = (r_mode == rac_pkg::MODE_SUBMIT) && r_rt && c_inrange
                         && c_sub_met_nz;
  assign sts.div_done = dv_busy && (dv_cnt == 5'd0);
  assign sts.scan_last = (scan_i == CW'(SLOTS - 1));

  // Per-slot deadline term for the slot under scan.
  logic [IW-1:0] sc_idx;
  logic          sc_use;
  logic [19:0]   sc_frame;
  logic [19:0]   sc_mus, sc_tus, sc_margin;
  logic [TB-1:0] sc_next, sc_late;
  always_comb begin
    sc_idx = scan_i[IW-1:0];
    sc_frame = s_frame[sc_idx];
    sc_mus = 20'(s_met[sc_idx] * 20'd1000);
    sc_tus = 20'(s_tol[sc_idx] * 20'd1000);
    sc_margin = (sc_frame >= sc_mus) ? sc_frame - sc_mus : 20'd0;
    if (sc_tus < sc_margin) sc_margin = sc_tus;
    sc_next = tadd(s_last[sc_idx], TB'({1'b0, sc_frame} + {1'b0, sc_margin}));
    sc_late = tadd(sc_next, TB'({sc_frame, 1'b0}));
    sc_use = (sc_idx != p_idx) && s_valid[sc_idx] && (s_fps[sc_idx] != 10'd0)
             && (s_last[sc_idx] != '0) && !(sc_late < r_now);
  end

  // Frame-time check for set.
  logic [19:0] f_mus, f_tus;
  logic        f_bad;
  always_comb begin
    f_mus = 20'(p_m * 20'd1000);
    f_tus = 20'(p_t * 20'd1000);
    f_bad = (p_m == 10'd0) || (dv_q < f_mus) || (f_tus > dv_q - f_mus);
  end

  logic [TB-1:0] bk_max, need;
  always_comb begin
    bk_max = (r_now > booked) ? r_now : booked;
    need = tadd(bk_max, TB'(p_m * 20'd1000));
  end

  // Result of the transaction, taken at the finish step.
  logic [1:0]    fin_status;
  logic          fin_fwd;
  logic [TB-1:0] fin_booked;
  logic          fin_set_ok;
  always_comb begin
    fin_status = rac_pkg::ST_OK;
    fin_fwd = 1'b0;
    fin_booked = booked;
    fin_set_ok = !p_bad && !(p_f != 10'd0 && f_bad);
    unique case (r_mode)
      rac_pkg::MODE_SUBMIT: begin
        if (!r_rt) fin_fwd = 1'b1;
        else if (!p_inrange) fin_status = rac_pkg::ST_INVAL;
        else if (p_m == 10'd0) begin
          fin_status = (p_was_valid && s_fps[p_idx] != 10'd0) ? rac_pkg::ST_INVAL
                                                               : rac_pkg::ST_DEADLINE;
        end else if (!has_dl || deadline > need) begin
          fin_booked = need;
          fin_fwd = 1'b1;
        end else begin
          fin_booked = bk_max;
          fin_status = rac_pkg::ST_DEADLINE;
        end
      end
      rac_pkg::MODE_SET: begin
        if (!fin_set_ok) fin_status = rac_pkg::ST_INVAL;
      end
      rac_pkg::MODE_REMOVE: ;
      rac_pkg::MODE_QUERY: begin
        if (!p_was_valid) fin_status = rac_pkg::ST_NOTFOUND;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= '0;
      booked <= '0;
      dv_busy <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        s_fps[k] <= '0;
        s_met[k] <= '0;
        s_tol[k] <= '0;
        s_frame[k] <= '0;
        s_last[k] <= '0;
      end
    end else begin
      if (cmd.load) begin
        r_mode <= mode;
        r_slot <= slot;
        r_now <= TB'(now_us);
        r_f <= fps_in;
        r_m <= met_ms_in;
        r_t <= tolerance_ms_in;
        r_rt <= realtime_enable;
      end
      if (cmd.prep) begin
        p_inrange <= c_inrange;
        p_idx <= c_idx;
        p_was_valid <= c_valid;
        p_bad <= c_bad;
        p_f <= c_f[9:0];
        p_m <= (r_mode == rac_pkg::MODE_SUBMIT) ? (c_valid ? s_met[c_idx] : 10'd0)
                                                : c_m[9:0];
        p_t <= c_t[9:0];
        if (r_mode == rac_pkg::MODE_SUBMIT) begin
          // Stamp the arrival so the scan reads the updated table.
          if (r_rt && c_inrange) begin
            if (!c_valid) begin
              s_fps[c_idx] <= '0;
              s_met[c_idx] <= '0;
              s_tol[c_idx] <= '0;
              s_frame[c_idx] <= '0;
            end
            s_last[c_idx] <= r_now;
            s_valid[c_idx] <= 1'b1;
          end
        end
        scan_i <= '0;
        has_dl <= 1'b0;
        deadline <= '0;
        dv_q <= '0;
      end
      if (cmd.div_start) begin
        dv_r <= '0;
        dv_cnt <= 5'd20;
        dv_busy <= 1'b1;
      end else if (dv_busy && dv_cnt != 5'd0) begin
        // Restoring division, one quotient bit a cycle.
        logic [20:0] tr;
        logic [19:0] dd;
        dd = 20'd1000000;
        tr = {dv_r, dd[dv_cnt - 5'd1]};
        if (tr >= {11'd0, p_f}) begin
          dv_r <= 20'(tr - {11'd0, p_f});
          dv_q <= {dv_q[18:0], 1'b1};
        end else begin
          dv_r <= tr[19:0];
          dv_q <= {dv_q[18:0], 1'b0};
        end
        dv_cnt <= dv_cnt - 5'd1;
      end else begin
        dv_busy <= 1'b0;
      end
      if (cmd.scan) begin
        if (sc_use && (!has_dl || sc_next < deadline)) begin
          deadline <= sc_next;
          has_dl <= 1'b1;
        end
        scan_i <= scan_i + CW'(1);
      end
      if (cmd.finish) begin
        status <= fin_status;
        forwarded <= fin_fwd;
        booked <= fin_booked;
        if (r_mode == rac_pkg::MODE_QUERY && p_was_valid) begin
          last_arrival_us <= 48'(s_last[p_idx]);
          fps_out <= s_fps[p_idx];
          met_ms_out <= s_met[p_idx];
          tolerance_ms_out <= s_tol[p_idx];
        end else begin
          last_arrival_us <= '0;
          fps_out <= '0;
          met_ms_out <= '0;
          tolerance_ms_out <= '0;
        end
        if (r_mode == rac_pkg::MODE_SET && fin_set_ok) begin
          s_fps[p_idx] <= p_f;
          s_met[p_idx] <= p_m;
          s_tol[p_idx] <= p_t;
          s_frame[p_idx] <= dv_q;
          s_last[p_idx] <= '0;
          s_valid[p_idx] <= 1'b1;
        end
        if (r_mode == rac_pkg::MODE_REMOVE && p_inrange) begin
          s_fps[p_idx] <= '0;
          s_met[p_idx] <= '0;
          s_tol[p_idx] <= '0;
          s_frame[p_idx] <= '0;
          s_last[p_idx] <= '0;
          s_valid[p_idx] <= 1'b0;
        end
      end
    end
  end

  assign booked_time_us = 48'(booked);
endmodule

### hdl/realtime_admission_control.sv
// Top level of the real-time admission control block.
//   channel  | handshake           | payload
//   in       | in_valid/in_ready   | mode, slot, now_us, fps_in, met_ms_in, tolerance_ms_in
//   out      | out_valid/out_ready | status, forwarded, booked_time_us, last_arrival_us, *_out
//   config   | cfg_we              | cfg_wdata (realtime_enable)
// One transaction at a time. Remove and query go through the prepare and finish
// states to a result; a valid set with nonzero fps also runs the 20-step frame-time
// divider, and a real-time submit whose slot holds a nonzero met also scans all SLOTS slots.
// Reset clears the table, booked time and realtime_enable.
// A stalled result holds in the output registers; no new input is taken meanwhile.
module realtime_admission_control #(
  parameter int SLOTS = rac_pkg::SLOTS_DEF,
  parameter int TIME_BITS = rac_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [2:0]         slot,
  input  logic [47:0]        now_us,
  input  logic signed [10:0] fps_in,
  input  logic signed [10:0] met_ms_in,
  input  logic signed [10:0] tolerance_ms_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               forwarded,
  output logic [47:0]        booked_time_us,
  output logic [47:0]        last_arrival_us,
  output logic [9:0]         fps_out,
  output logic [9:0]         met_ms_out,
  output logic [9:0]         tolerance_ms_out
);
  rac_pkg::rac_cmd_t cmd;
  rac_pkg::rac_sts_t sts;
  logic realtime_enable;

  always_ff @(posedge clk) begin
    if (rst) realtime_enable <= 1'b0;
    else if (cfg_we) realtime_enable <= cfg_wdata;
  end

  rac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  rac_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .realtime_enable(realtime_enable),
    .mode(mode), .slot(slot), .now_us(now_us), .fps_in(fps_in),
    .met_ms_in(met_ms_in), .tolerance_ms_in(tolerance_ms_in), .status(status),
    .forwarded(forwarded), .booked_time_us(booked_time_us),
    .last_arrival_us(last_arrival_us), .fps_out(fps_out), .met_ms_out(met_ms_out),
    .tolerance_ms_out(tolerance_ms_out)
  );
endmodule

### hdl/rac_checker.sv
// Port-level checks for the admission control block.
module rac_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic       forwarded
);
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_accept_no_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_fwd_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && forwarded) |-> status == rac_pkg::ST_OK)
    else $error("forwarded with error status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status))
    else $error("result dropped");
endmodule

bind realtime_admission_control rac_checker u_rac_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status), .forwarded(forwarded)
);
